FILE: rtl/core/imm_pkg.sv
package imm_pkg;

  // Largest matrix dimension held in the stores
  localparam int MAX_DIM = 8;

  // Field widths fixed by the interface
  localparam int ROW_W   = 3;
  localparam int DIMF_W  = 4;
  localparam int DATA_W  = 32;
  localparam int CIDX_W  = 2;

  // Derived sizes
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_A_ROWS     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_B_COLS     = 2'd2,
    CFG_SPARE      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    action_t              action;
    logic [ROW_W-1:0]     row;
    logic [ROW_W-1:0]     col;
    logic [DIMF_W-1:0]    end_row;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]     out_row;
    logic [ROW_W-1:0]     out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                 last;
  } result_t;

  // Tag that travels with one multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic             zero;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } step_t;

  // Clamp a dimension register to the store size
  function automatic logic [CNT_W-1:0] sat_dim(input logic [DIMF_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v > DIMF_W'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/integer_matrix_multiply.sv
// Channel   Handshake                 Payload
// command   start / busy              cmd (imm_pkg::cmd_t)
// result    result_valid strobe       result (imm_pkg::result_t)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An element write leaves busy low, so writes stream every cycle while no compute runs.
// A compute holds busy for rows in range * cols * max(inner_size, 1) steps of the shared
// multiply-accumulate unit and while it drains the read and product stages; busy falls
// the cycle after the final strobe.
// Results appear one per strobe at the end of each inner sum; the receiver cannot stall.
// Synchronous reset sets all three dimensions to the maximum; the stores are not cleared.
module integer_matrix_multiply (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  imm_pkg::cmd_t               cmd,
  output logic                        result_valid,
  output imm_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [imm_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [imm_pkg::DIMF_W-1:0]  cfg_data
);

  logic                        accept;
  logic                        in_range;
  logic                        a_we;
  logic                        b_we;
  logic [imm_pkg::ADDR_W-1:0]  waddr;
  logic [imm_pkg::ADDR_W-1:0]  a_addr;
  logic [imm_pkg::ADDR_W-1:0]  b_addr;
  logic [imm_pkg::DATA_W-1:0]  a_data;
  logic [imm_pkg::DATA_W-1:0]  b_data;
  logic                        pending;
  imm_pkg::step_t              step;

  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // Drop element writes that fall outside the store
  assign in_range = (imm_pkg::DIMF_W'(cmd.row) < imm_pkg::DIMF_W'(imm_pkg::MAX_DIM)) &&
                    (imm_pkg::DIMF_W'(cmd.col) < imm_pkg::DIMF_W'(imm_pkg::MAX_DIM));
  assign waddr    = imm_pkg::ADDR_W'(cmd.row) * imm_pkg::ADDR_W'(imm_pkg::MAX_DIM) +
                    imm_pkg::ADDR_W'(cmd.col);
  assign a_we     = accept && in_range && (cmd.action == imm_pkg::ACT_WRITE_A);
  assign b_we     = accept && in_range && (cmd.action == imm_pkg::ACT_WRITE_B);

  imm_ram #(
    .WIDTH (imm_pkg::DATA_W),
    .DEPTH (imm_pkg::DEPTH)
  ) u_first_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (a_addr),
    .rdata (a_data)
  );

  imm_ram #(
    .WIDTH (imm_pkg::DATA_W),
    .DEPTH (imm_pkg::DEPTH)
  ) u_second_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (b_addr),
    .rdata (b_data)
  );

  imm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .busy      (busy),
    .step      (step),
    .a_addr    (a_addr),
    .b_addr    (b_addr)
  );

  imm_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .a_data       (a_data),
    .b_data       (b_data),
    .pending      (pending),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

FILE: rtl/core/imm_ram.sv
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/imm_mac.sv
module imm_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  imm_pkg::step_t              step,
  input  logic [imm_pkg::DATA_W-1:0]  a_data,
  input  logic [imm_pkg::DATA_W-1:0]  b_data,
  output logic                        pending,
  output logic                        result_valid,
  output imm_pkg::result_t            result
);

  imm_pkg::step_t              tag1;
  imm_pkg::step_t              tag2;
  logic [imm_pkg::DATA_W-1:0]  prod;
  logic [imm_pkg::DATA_W-1:0]  acc;
  logic [imm_pkg::DATA_W-1:0]  prod_next;
  logic [imm_pkg::DATA_W-1:0]  sum_next;

  // Low word of the product is all that survives the wrap
  assign prod_next = tag1.zero ? '0 : a_data * b_data;
  assign sum_next  = (tag2.first ? '0 : acc) + prod;
  assign pending   = tag1.valid | tag2.valid;

  // Advance tags alongside read data, product and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid   <= 1'b0;
      tag2.valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      tag1.valid   <= step.valid;
      tag2.valid   <= tag1.valid;
      result_valid <= tag2.valid & tag2.lastk;
    end
    tag1.first <= step.first;
    tag1.lastk <= step.lastk;
    tag1.zero  <= step.zero;
    tag1.last  <= step.last;
    tag1.row   <= step.row;
    tag1.col   <= step.col;
    tag2.first <= tag1.first;
    tag2.lastk <= tag1.lastk;
    tag2.zero  <= tag1.zero;
    tag2.last  <= tag1.last;
    tag2.row   <= tag1.row;
    tag2.col   <= tag1.col;
    prod       <= prod_next;
    if (tag2.valid) begin
      acc              <= sum_next;
      result.out_row   <= tag2.row;
      result.out_col   <= tag2.col;
      result.out_value <= sum_next;
      result.last      <= tag2.last;
    end
  end

endmodule

FILE: rtl/core/imm_ctrl.sv
module imm_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  imm_pkg::cmd_t                     cmd,
  input  logic                              cfg_valid,
  input  logic [imm_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [imm_pkg::DIMF_W-1:0]        cfg_data,
  input  logic                              pending,
  output logic                              busy,
  output imm_pkg::step_t                    step,
  output logic [imm_pkg::ADDR_W-1:0]        a_addr,
  output logic [imm_pkg::ADDR_W-1:0]        b_addr
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t                         state;
  logic [imm_pkg::DIMF_W-1:0]     a_rows;
  logic [imm_pkg::DIMF_W-1:0]     inner_size;
  logic [imm_pkg::DIMF_W-1:0]     b_cols;
  logic [imm_pkg::CNT_W-1:0]      i_cnt;
  logic [imm_pkg::CNT_W-1:0]      j_cnt;
  logic [imm_pkg::CNT_W-1:0]      k_cnt;
  logic [imm_pkg::CNT_W-1:0]      end_lim;
  logic [imm_pkg::CNT_W-1:0]      cols;
  logic [imm_pkg::CNT_W-1:0]      inner;

  logic                           accept;
  logic [imm_pkg::CNT_W-1:0]      rows_sat;
  logic [imm_pkg::CNT_W-1:0]      end_next;
  logic [imm_pkg::CNT_W-1:0]      cols_next;
  logic                           run_ok;
  logic                           k_last;
  logic                           j_last;
  logic                           i_last;

  assign accept    = start & ~busy;
  assign busy      = (state != ST_IDLE);
  assign rows_sat  = imm_pkg::sat_dim(a_rows);
  assign cols_next = imm_pkg::sat_dim(b_cols);
  assign end_next  = (cmd.end_row > imm_pkg::DIMF_W'(rows_sat)) ? rows_sat
                                                                 : imm_pkg::CNT_W'(cmd.end_row);
  assign run_ok    = (imm_pkg::DIMF_W'(cmd.row) < imm_pkg::DIMF_W'(end_next)) &&
                     (cols_next != '0);

  // An empty inner dimension still takes one zero step per entry
  assign k_last = (inner == '0) || (k_cnt + 1'b1 == inner);
  assign j_last = (j_cnt + 1'b1 == cols);
  assign i_last = (i_cnt + 1'b1 == end_lim);

  // Issue one product step per cycle
  always_comb begin
    step.valid = (state == ST_RUN);
    step.first = (k_cnt == '0);
    step.lastk = k_last;
    step.zero  = (inner == '0);
    step.last  = i_last & j_last;
    step.row   = imm_pkg::ROW_W'(i_cnt);
    step.col   = imm_pkg::ROW_W'(j_cnt);
    a_addr = imm_pkg::ADDR_W'(i_cnt) * imm_pkg::ADDR_W'(imm_pkg::MAX_DIM) +
             imm_pkg::ADDR_W'(k_cnt);
    b_addr = imm_pkg::ADDR_W'(k_cnt) * imm_pkg::ADDR_W'(imm_pkg::MAX_DIM) +
             imm_pkg::ADDR_W'(j_cnt);
  end

  // Hold configuration, sequence the i, j, k walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      a_rows     <= imm_pkg::DIMF_W'(imm_pkg::MAX_DIM);
      inner_size <= imm_pkg::DIMF_W'(imm_pkg::MAX_DIM);
      b_cols     <= imm_pkg::DIMF_W'(imm_pkg::MAX_DIM);
    end else begin
      if (cfg_valid) begin
        case (imm_pkg::cfg_idx_t'(cfg_index))
          imm_pkg::CFG_A_ROWS:     a_rows     <= cfg_data;
          imm_pkg::CFG_INNER_SIZE: inner_size <= cfg_data;
          imm_pkg::CFG_B_COLS:     b_cols     <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept && cmd.action == imm_pkg::ACT_COMPUTE && run_ok) begin
            state   <= ST_RUN;
            i_cnt   <= imm_pkg::CNT_W'(cmd.row);
            j_cnt   <= '0;
            k_cnt   <= '0;
            end_lim <= end_next;
            cols    <= cols_next;
            inner   <= imm_pkg::sat_dim(inner_size);
          end
        end
        ST_RUN: begin
          if (k_last) begin
            k_cnt <= '0;
            if (j_last) begin
              j_cnt <= '0;
              i_cnt <= i_cnt + 1'b1;
              if (i_last) begin
                state <= ST_DRAIN;
              end
            end else begin
              j_cnt <= j_cnt + 1'b1;
            end
          end else begin
            k_cnt <= k_cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!pending) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: test/matmul_checker.sv
`timescale 1ns / 100ps

module matmul_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  imm_pkg::cmd_t              cmd,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [imm_pkg::CIDX_W-1:0] cfg_index,
  input  logic [imm_pkg::DIMF_W-1:0] cfg_data,
  input  logic                       result_valid,
  input  imm_pkg::result_t           result,
  output int                         fail_count,
  output int                         outstanding
);

  // Shadow copies of both matrices and of the dimension registers
  logic [imm_pkg::DATA_W-1:0] first_mat  [imm_pkg::MAX_DIM][imm_pkg::MAX_DIM];
  logic [imm_pkg::DATA_W-1:0] second_mat [imm_pkg::MAX_DIM][imm_pkg::MAX_DIM];
  logic [imm_pkg::DIMF_W-1:0] rows_reg;
  logic [imm_pkg::DIMF_W-1:0] inner_reg;
  logic [imm_pkg::DIMF_W-1:0] cols_reg;

  // Product entries still owed by the block, oldest first
  imm_pkg::result_t expected_entries [$];

  function automatic int clamp_dim(input logic [imm_pkg::DIMF_W-1:0] v);
    return (v > imm_pkg::MAX_DIM) ? imm_pkg::MAX_DIM : int'(v);
  endfunction

  // Queue every entry of the requested row range, flagging the last one
  function automatic void predict_product_rows(input imm_pkg::cmd_t c);
    int n_rows;
    int n_inner;
    int n_cols;
    int stop_row;
    int n_pushed;
    logic [imm_pkg::DATA_W-1:0] acc;
    imm_pkg::result_t entry;
    n_rows   = clamp_dim(rows_reg);
    n_inner  = clamp_dim(inner_reg);
    n_cols   = clamp_dim(cols_reg);
    stop_row = (int'(c.end_row) > n_rows) ? n_rows : int'(c.end_row);
    n_pushed = 0;
    for (int i = int'(c.row); i < stop_row; i++) begin
      for (int j = 0; j < n_cols; j++) begin
        acc = '0;
        for (int k = 0; k < n_inner; k++) begin
          acc = acc + first_mat[i][k] * second_mat[k][j];
        end
        entry.out_row   = imm_pkg::ROW_W'(i);
        entry.out_col   = imm_pkg::ROW_W'(j);
        entry.out_value = acc;
        entry.last      = 1'b0;
        expected_entries.push_back(entry);
        n_pushed++;
      end
    end
    if (n_pushed > 0) begin
      expected_entries[expected_entries.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    imm_pkg::result_t want;
    if (rst) begin
      rows_reg  = 4'd8;
      inner_reg = 4'd8;
      cols_reg  = 4'd8;
      expected_entries.delete();
    end else begin
      // Check each result strobe against the oldest owed entry
      if (result_valid) begin
        if (expected_entries.size() == 0) begin
          $display("%0t: unexpected result row %0d col %0d value %0d last %0b",
                   $time, result.out_row, result.out_col, result.out_value, result.last);
          fail_count++;
        end else begin
          want = expected_entries.pop_front();
          if (result.out_row !== want.out_row) begin
            $display("%0t: out_row expected %0d got %0d", $time, want.out_row, result.out_row);
            fail_count++;
          end
          if (result.out_col !== want.out_col) begin
            $display("%0t: out_col expected %0d got %0d", $time, want.out_col, result.out_col);
            fail_count++;
          end
          if (result.out_value !== want.out_value) begin
            $display("%0t: out_value at (%0d,%0d) expected %0d got %0d", $time,
                     want.out_row, want.out_col, want.out_value, result.out_value);
            fail_count++;
          end
          if (result.last !== want.last) begin
            $display("%0t: last at (%0d,%0d) expected %0b got %0b", $time,
                     want.out_row, want.out_col, want.last, result.last);
            fail_count++;
          end
        end
      end

      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (imm_pkg::cfg_idx_t'(cfg_index))
          imm_pkg::CFG_A_ROWS:     rows_reg  = cfg_data;
          imm_pkg::CFG_INNER_SIZE: inner_reg = cfg_data;
          imm_pkg::CFG_B_COLS:     cols_reg  = cfg_data;
          default: ;
        endcase
      end

      // Apply each command transfer
      if (start && !busy) begin
        case (cmd.action)
          imm_pkg::ACT_WRITE_A: first_mat[cmd.row][cmd.col]  = cmd.value;
          imm_pkg::ACT_WRITE_B: second_mat[cmd.row][cmd.col] = cmd.value;
          imm_pkg::ACT_COMPUTE: predict_product_rows(cmd);
          default: ;
        endcase
      end
    end
    outstanding <= expected_entries.size();
  end

endmodule

FILE: test/integer_matrix_multiply_tb.sv
`timescale 1ns / 100ps

module integer_matrix_multiply_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int TARGET_ITEMS  = 170;
  localparam int QUIET_TAIL    = 30;
  localparam int SETTLE_CYCLES = 12;
  localparam int SMALL_BUDGET  = 40;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       start        = 1'b0;
  logic                       busy;
  imm_pkg::cmd_t              cmd          = '0;
  logic                       result_valid;
  imm_pkg::result_t           result;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  logic [imm_pkg::CIDX_W-1:0] cfg_index    = '0;
  logic [imm_pkg::DIMF_W-1:0] cfg_data     = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int sent_items  = 0;

  // Which store entries hold a value, so no compute reads an empty one
  bit            a_loaded [imm_pkg::MAX_DIM][imm_pkg::MAX_DIM];
  bit            b_loaded [imm_pkg::MAX_DIM][imm_pkg::MAX_DIM];
  imm_pkg::cmd_t load_plan [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  integer_matrix_multiply dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  matmul_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int eff_dim(input logic [imm_pkg::DIMF_W-1:0] v);
    return (v > imm_pkg::MAX_DIM) ? imm_pkg::MAX_DIM : int'(v);
  endfunction

  // Mostly small dimensions, now and then zero, full size or saturating
  function automatic logic [imm_pkg::DIMF_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return imm_pkg::DIMF_W'($urandom_range(1, 3));
    if (r < 12) return imm_pkg::DIMF_W'($urandom_range(4, 7));
    if (r == 12) return '0;
    if (r == 13) return imm_pkg::DIMF_W'(imm_pkg::MAX_DIM);
    return imm_pkg::DIMF_W'($urandom_range(9, 15));
  endfunction

  // Lean towards the wrap-around extremes and small signed values
  function automatic logic [imm_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return imm_pkg::DATA_W'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  function automatic imm_pkg::cmd_t make_item(input imm_pkg::action_t act, input int r,
                                              input int c,
                                              input logic [imm_pkg::DATA_W-1:0] v);
    imm_pkg::cmd_t item;
    item.action  = act;
    item.row     = imm_pkg::ROW_W'(r);
    item.col     = imm_pkg::ROW_W'(c);
    item.end_row = imm_pkg::DIMF_W'($urandom_range(0, 15));
    item.value   = v;
    return item;
  endfunction

  function automatic imm_pkg::cmd_t make_compute(input int first_row, input int stop_row);
    imm_pkg::cmd_t item;
    item.action  = imm_pkg::ACT_COMPUTE;
    item.row     = imm_pkg::ROW_W'(first_row);
    item.col     = imm_pkg::ROW_W'($urandom_range(0, 7));
    item.end_row = imm_pkg::DIMF_W'(stop_row);
    item.value   = $urandom();
    return item;
  endfunction

  // Idle commands or stray element writes anywhere in the stores
  function automatic imm_pkg::cmd_t noise_item();
    imm_pkg::action_t act;
    act = $urandom_range(0, 1) ? imm_pkg::ACT_NONE
                               : imm_pkg::action_t'(2'($urandom_range(0, 1)));
    return make_item(act, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
  endfunction

  // Compute over rows that are already loaded; sometimes an empty range
  function automatic imm_pkg::cmd_t compute_item(input int n_rows);
    int first_row;
    if (n_rows > 0 && $urandom_range(0, 3) != 0) begin
      first_row = $urandom_range(0, n_rows - 1);
      return make_compute(first_row, $urandom_range(first_row + 1, 15));
    end
    return make_compute($urandom_range(0, 7), $urandom_range(0, 15));
  endfunction

  // Hold start and the command until the block takes it; idle first at random
  task automatic issue_cmd(input imm_pkg::cmd_t c);
    if (sent_items < TARGET_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sent_items++;
    if (c.action == imm_pkg::ACT_WRITE_A) a_loaded[c.row][c.col] = 1'b1;
    if (c.action == imm_pkg::ACT_WRITE_B) b_loaded[c.row][c.col] = 1'b1;
  endtask

  // Write all three dimension registers as back-to-back transfers
  task automatic set_dims(input logic [imm_pkg::DIMF_W-1:0] n_rows,
                          input logic [imm_pkg::DIMF_W-1:0] n_inner,
                          input logic [imm_pkg::DIMF_W-1:0] n_cols);
    imm_pkg::cfg_idx_t          reg_order [3] = '{imm_pkg::CFG_A_ROWS,
                                                  imm_pkg::CFG_INNER_SIZE,
                                                  imm_pkg::CFG_B_COLS};
    logic [imm_pkg::DIMF_W-1:0] dim_vals  [3];
    dim_vals = '{n_rows, n_inner, n_cols};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= reg_order[i];
      cfg_data  <= dim_vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drop start and wait until every owed entry has come and the block is quiet
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // New dimensions, a shuffled load of the operands in use, then a few computes
  task automatic random_phase();
    logic [imm_pkg::DIMF_W-1:0] d_rows;
    logic [imm_pkg::DIMF_W-1:0] d_inner;
    logic [imm_pkg::DIMF_W-1:0] d_cols;
    int            n_rows;
    int            n_inner;
    int            n_cols;
    int            pick;
    imm_pkg::cmd_t held;
    // Keep the operands small near the end so the item count stays close to the target
    if (TARGET_ITEMS - sent_items < SMALL_BUDGET) begin
      d_rows  = imm_pkg::DIMF_W'($urandom_range(1, 3));
      d_inner = imm_pkg::DIMF_W'($urandom_range(1, 3));
      d_cols  = imm_pkg::DIMF_W'($urandom_range(1, 3));
    end else begin
      d_rows  = pick_dim();
      d_inner = pick_dim();
      d_cols  = pick_dim();
    end
    set_dims(d_rows, d_inner, d_cols);
    n_rows  = eff_dim(d_rows);
    n_inner = eff_dim(d_inner);
    n_cols  = eff_dim(d_cols);

    load_plan.delete();
    for (int i = 0; i < n_rows; i++) begin
      for (int k = 0; k < n_inner; k++) begin
        if (!a_loaded[i][k] || $urandom_range(0, 1) == 1)
          load_plan.push_back(make_item(imm_pkg::ACT_WRITE_A, i, k, pick_value()));
      end
    end
    for (int k = 0; k < n_inner; k++) begin
      for (int j = 0; j < n_cols; j++) begin
        if (!b_loaded[k][j] || $urandom_range(0, 1) == 1)
          load_plan.push_back(make_item(imm_pkg::ACT_WRITE_B, k, j, pick_value()));
      end
    end
    for (int i = load_plan.size() - 1; i > 0; i--) begin
      pick            = $urandom_range(0, i);
      held            = load_plan[i];
      load_plan[i]    = load_plan[pick];
      load_plan[pick] = held;
    end

    foreach (load_plan[i]) begin
      if ($urandom_range(0, 9) == 0) issue_cmd(noise_item());
      issue_cmd(load_plan[i]);
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) issue_cmd(noise_item());
      issue_cmd(compute_item(n_rows));
    end
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two by two product of the signed extremes, plus corner writes and range edges
    set_dims(4'd2, 4'd2, 4'd2);
    issue_cmd(make_item(imm_pkg::ACT_WRITE_A, 0, 0, 32'h7FFF_FFFF));
    issue_cmd(make_item(imm_pkg::ACT_WRITE_A, 0, 1, 32'h8000_0000));
    issue_cmd(make_item(imm_pkg::ACT_WRITE_A, 1, 0, 32'hFFFF_FFFF));
    issue_cmd(make_item(imm_pkg::ACT_WRITE_A, 1, 1, 32'h0000_0000));
    issue_cmd(make_item(imm_pkg::ACT_WRITE_B, 0, 0, 32'h8000_0000));
    issue_cmd(make_item(imm_pkg::ACT_WRITE_B, 0, 1, 32'hFFFF_FFFF));
    issue_cmd(make_item(imm_pkg::ACT_WRITE_B, 1, 0, 32'h7FFF_FFFF));
    issue_cmd(make_item(imm_pkg::ACT_WRITE_B, 1, 1, 32'h0000_0001));
    issue_cmd(make_item(imm_pkg::ACT_WRITE_A, 7, 7, 32'h5555_5555));
    issue_cmd(make_item(imm_pkg::ACT_WRITE_B, 7, 7, 32'hAAAA_AAAA));
    issue_cmd(make_item(imm_pkg::ACT_NONE, 7, 7, $urandom()));
    issue_cmd(make_compute(0, 2));
    issue_cmd(make_compute(1, 15));
    issue_cmd(make_compute(2, 1));
    issue_cmd(make_compute(0, 0));
    settle();

    // Empty inner sum with saturated column count: a row of zeros
    set_dims(4'd1, 4'd0, 4'd15);
    issue_cmd(make_compute(0, 8));
    settle();

    // No rows in use: nothing comes back
    set_dims(4'd0, 4'd2, 4'd2);
    issue_cmd(make_compute(0, 8));
    settle();

    while (sent_items < TARGET_ITEMS) random_phase();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
